// ===== sv/esc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  // Register indexes
  localparam logic [2:0] REG_TEMP   = 3'd0;
  localparam logic [2:0] REG_PLOW   = 3'd1;
  localparam logic [2:0] REG_PHIGH  = 3'd2;
  localparam logic [2:0] REG_MIXED  = 3'd3;
  localparam logic [2:0] REG_HUM    = 3'd4;
  localparam int         CFG_DATA_W = 64;
  localparam int         CFG_IDX_W  = 3;

  // Compensation constants
  localparam logic [63:0] T_OFFSET  = 64'd128000;
  localparam logic [63:0] P_BASE    = 64'd1048576;
  localparam logic [63:0] P_SCALE   = 64'd3125;
  localparam logic [63:0] P_BIAS    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] H_OFFSET  = 32'd76800;
  localparam logic [31:0] H_MAX     = 32'd419430400;
  localparam logic [31:0] H_ROUND_A = 32'd2097152;
  localparam logic [31:0] H_ROUND_B = 32'd16384;
  localparam logic [31:0] H_ROUND_C = 32'd32768;
  localparam logic [31:0] H_ROUND_D = 32'd8192;
  localparam logic [31:0] T_ROUND   = 32'd128;
  localparam logic [63:0] P_MAX     = 64'h0000_0000_FFFF_FFFF;

  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
  } out_t;

  typedef struct packed {
    logic [47:0] t;
    logic [63:0] pl;
    logic [63:0] ph;
    logic [47:0] mx;
    logic [39:0] hm;
  } cfg_t;

  // Entry passed from front to back
  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic [19:0] ap;
    logic [15:0] ah;
  } q_t;

  // Fields that ride along the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        valid;
  } side_t;

  // Partial products of a 64-bit wrapping multiply
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] xa;
    logic [31:0] xb;
  } pp_t;

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    r.xa = a[31:0] * b[63:32];
    r.xb = a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] x;
    x = p.xa + p.xb;
    return p.ll + {x, 32'b0};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16w(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== sv/esc_front.sv =====
// Front end: accepts raw samples and compensates temperature.
`timescale 1ns / 1ps
`default_nettype none
module esc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire esc_pkg::in_t sample,
  input  wire esc_pkg::cfg_t cfg,
  output logic              push,
  output esc_pkg::q_t       entry
);

  typedef struct packed {
    logic [19:0] at;
    logic [19:0] ap;
    logic [15:0] ah;
    logic [31:0] x0;
    logic [31:0] x1;
  } fr_t;

  logic [31:0] t1, t2, t3;
  logic [4:0]  vld;
  fr_t         s0, s1, s2, s3, s4;

  assign t1 = {16'b0, cfg.t[15:0]};
  assign t2 = esc_pkg::sx16(cfg.t[31:16]);
  assign t3 = esc_pkg::sx16(cfg.t[47:32]);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], accept};
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    s0.at <= sample.raw_temperature;
    s0.ap <= sample.raw_pressure;
    s0.ah <= sample.raw_humidity;
    s0.x0 <= '0;
    s0.x1 <= '0;
  end

  // Offset terms
  always_ff @(posedge clk) begin
    fr_t s1_next;
    s1_next    = s0;
    s1_next.x0 = {15'b0, s0.at[19:3]} - (t1 << 1);
    s1_next.x1 = {16'b0, s0.at[19:4]} - t1;
    s1         <= s1_next;
  end

  // Products
  always_ff @(posedge clk) begin
    fr_t s2_next;
    s2_next    = s1;
    s2_next.x0 = s1.x0 * t2;
    s2_next.x1 = s1.x1 * s1.x1;
    s2         <= s2_next;
  end

  // Scale and apply T3
  always_ff @(posedge clk) begin
    fr_t s3_next;
    s3_next    = s2;
    s3_next.x0 = esc_pkg::asr32(s2.x0, 11);
    s3_next.x1 = esc_pkg::asr32(s2.x1, 12) * t3;
    s3         <= s3_next;
  end

  // Fine temperature
  always_ff @(posedge clk) begin
    fr_t s4_next;
    s4_next    = s3;
    s4_next.x0 = s3.x0 + esc_pkg::asr32(s3.x1, 14);
    s4         <= s4_next;
  end

  // Temperature in hundredths, push to the queue
  assign push       = vld[4];
  assign entry.fine = s4.x0;
  assign entry.temp = esc_pkg::asr32((s4.x0 << 2) + s4.x0 + esc_pkg::T_ROUND, 8);
  assign entry.ap   = s4.ap;
  assign entry.ah   = s4.ah;

endmodule
`default_nettype wire

// ===== sv/esc_fifo.sv =====
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module esc_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire esc_pkg::q_t wdata,
  input  wire logic        pop,
  output logic             nonempty,
  output logic             full,
  output esc_pkg::q_t      rdata
);

  esc_pkg::q_t mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign nonempty = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign rdata    = mem[rptr];

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Track pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== sv/esc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module esc_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_vld,
  input  wire logic [63:0]    num,
  input  wire logic [63:0]    den,
  input  wire esc_pkg::side_t in_side,
  output logic                out_vld,
  output logic [63:0]         quo,
  output esc_pkg::side_t      out_side
);

  typedef struct packed {
    logic [63:0]    rem;
    logic [63:0]    n;
    logic [63:0]    d;
    logic           neg;
    esc_pkg::side_t side;
  } dv_t;

  dv_t  st  [esc_pkg::DIV_STEPS + 1];
  logic vld [esc_pkg::DIV_STEPS + 1];

  // Take magnitudes
  always_ff @(posedge clk) begin
    st[0].rem  <= '0;
    st[0].n    <= num[63] ? (64'd0 - num) : num;
    st[0].d    <= den[63] ? (64'd0 - den) : den;
    st[0].neg  <= num[63] ^ den[63];
    st[0].side <= in_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  // Shift in one dividend bit and subtract where it fits
  for (genvar i = 1; i <= esc_pkg::DIV_STEPS; i++) begin : g_step
    logic [63:0] sh;
    assign sh = {st[i-1].rem[62:0], st[i-1].n[63]};

    always_ff @(posedge clk) begin
      dv_t st_next;
      st_next = st[i-1];
      if (sh >= st[i-1].d) begin
        st_next.rem = sh - st[i-1].d;
        st_next.n   = {st[i-1].n[62:0], 1'b1};
      end else begin
        st_next.rem = sh;
        st_next.n   = {st[i-1].n[62:0], 1'b0};
      end
      st[i] <= st_next;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Restore the sign
  assign out_vld  = vld[esc_pkg::DIV_STEPS];
  assign quo      = st[esc_pkg::DIV_STEPS].neg ? (64'd0 - st[esc_pkg::DIV_STEPS].n)
                                               : st[esc_pkg::DIV_STEPS].n;
  assign out_side = st[esc_pkg::DIV_STEPS].side;

endmodule
`default_nettype wire

// ===== sv/esc_back.sv =====
// Back end: pressure and humidity compensation fed from the queue.
`timescale 1ns / 1ps
`default_nettype none
module esc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_vld,
  input  wire esc_pkg::q_t   entry,
  input  wire esc_pkg::cfg_t cfg,
  output logic               done,
  output esc_pkg::out_t      result
);

  typedef struct packed {
    logic [31:0]  temp;
    logic [31:0]  fine;
    logic [19:0]  ap;
    logic [15:0]  ah;
    logic [63:0]  f;
    logic [63:0]  ff;
    logic [63:0]  fp5;
    logic [63:0]  fp2;
    logic [63:0]  m6;
    logic [63:0]  m3;
    logic [63:0]  v2;
    logic [63:0]  v1a;
    logic [63:0]  numa;
    logic [63:0]  v1;
    logic [63:0]  num;
    esc_pkg::pp_t pa;
    esc_pkg::pp_t pb;
    esc_pkg::pp_t pc;
    logic [31:0]  hv;
    logic [31:0]  hx;
    logic [31:0]  hy;
    logic [31:0]  hz;
    logic [31:0]  hw;
    logic [31:0]  hu;
    logic [31:0]  hm;
    logic [31:0]  hq;
    logic [31:0]  hr;
    logic [16:0]  hum;
  } bk_t;

  typedef struct packed {
    logic [63:0]    p;
    esc_pkg::pp_t   pa;
    esc_pkg::pp_t   pb;
    logic [63:0]    qq;
    logic [63:0]    p8p;
    logic [63:0]    v1b;
    logic [63:0]    v2b;
    logic [63:0]    pr;
    esc_pkg::side_t side;
  } pt_t;

  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign p1 = {48'b0, cfg.pl[15:0]};
  assign p2 = esc_pkg::sx16w(cfg.pl[31:16]);
  assign p3 = esc_pkg::sx16w(cfg.pl[47:32]);
  assign p4 = esc_pkg::sx16w(cfg.pl[63:48]);
  assign p5 = esc_pkg::sx16w(cfg.ph[15:0]);
  assign p6 = esc_pkg::sx16w(cfg.ph[31:16]);
  assign p7 = esc_pkg::sx16w(cfg.ph[47:32]);
  assign p8 = esc_pkg::sx16w(cfg.ph[63:48]);
  assign p9 = esc_pkg::sx16w(cfg.mx[15:0]);
  assign h1 = {24'b0, cfg.mx[23:16]};
  assign h2 = esc_pkg::sx16(cfg.mx[39:24]);
  assign h3 = {24'b0, cfg.mx[47:40]};
  assign h4 = esc_pkg::sx16(cfg.hm[15:0]);
  assign h5 = esc_pkg::sx16(cfg.hm[31:16]);
  assign h6 = {{24{cfg.hm[39]}}, cfg.hm[39:32]};

  bk_t         s1, s2, s3, s4, s5, s6, s7, s8, s9;
  logic [9:1]  vld;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[8:1], in_vld};
    end
  end

  // Offsets from fine temperature
  always_ff @(posedge clk) begin
    bk_t s1_next;
    s1_next      = '0;
    s1_next.temp = entry.temp;
    s1_next.fine = entry.fine;
    s1_next.ap   = entry.ap;
    s1_next.ah   = entry.ah;
    s1_next.f    = {{32{entry.fine[31]}}, entry.fine} - esc_pkg::T_OFFSET;
    s1_next.hv   = entry.fine - esc_pkg::H_OFFSET;
    s1           <= s1_next;
  end

  // First products
  always_ff @(posedge clk) begin
    bk_t s2_next;
    s2_next    = s1;
    s2_next.pa = esc_pkg::mul_pp(s1.f, s1.f);
    s2_next.pb = esc_pkg::mul_pp(s1.f, p5);
    s2_next.pc = esc_pkg::mul_pp(s1.f, p2);
    s2_next.hx = esc_pkg::asr32(({16'b0, s1.ah} << 14) - (h4 << 20) - h5 * s1.hv
                                + esc_pkg::H_ROUND_B, 15);
    s2_next.hy = esc_pkg::asr32(s1.hv * h6, 10);
    s2_next.hz = esc_pkg::asr32(s1.hv * h3, 11) + esc_pkg::H_ROUND_C;
    s2         <= s2_next;
  end

  always_ff @(posedge clk) begin
    bk_t s3_next;
    s3_next     = s2;
    s3_next.ff  = esc_pkg::mul_sum(s2.pa);
    s3_next.fp5 = esc_pkg::mul_sum(s2.pb);
    s3_next.fp2 = esc_pkg::mul_sum(s2.pc);
    s3_next.hw  = esc_pkg::asr32(s2.hy * s2.hz, 10) + esc_pkg::H_ROUND_A;
    s3          <= s3_next;
  end

  // Square times P6 and P3
  always_ff @(posedge clk) begin
    bk_t s4_next;
    s4_next    = s3;
    s4_next.pa = esc_pkg::mul_pp(s3.ff, p6);
    s4_next.pb = esc_pkg::mul_pp(s3.ff, p3);
    s4_next.hu = esc_pkg::asr32(s3.hw * h2 + esc_pkg::H_ROUND_D, 14);
    s4         <= s4_next;
  end

  always_ff @(posedge clk) begin
    bk_t s5_next;
    s5_next    = s4;
    s5_next.m6 = esc_pkg::mul_sum(s4.pa);
    s5_next.m3 = esc_pkg::mul_sum(s4.pb);
    s5_next.hm = s4.hx * s4.hu;
    s5         <= s5_next;
  end

  // Combine var1 and var2
  always_ff @(posedge clk) begin
    bk_t s6_next;
    s6_next     = s5;
    s6_next.v2  = s5.m6 + (s5.fp5 << 17) + (p4 << 35);
    s6_next.v1a = esc_pkg::asr64(s5.m3, 8) + (s5.fp2 << 12) + esc_pkg::P_BIAS;
    s6_next.hq  = esc_pkg::asr32(esc_pkg::asr32(s5.hm, 15) * esc_pkg::asr32(s5.hm, 15), 7);
    s6          <= s6_next;
  end

  // Scale by P1, form the dividend
  always_ff @(posedge clk) begin
    bk_t s7_next;
    s7_next      = s6;
    s7_next.pa   = esc_pkg::mul_pp(s6.v1a, p1);
    s7_next.numa = ((esc_pkg::P_BASE - {44'b0, s6.ap}) << 31) - s6.v2;
    s7_next.hr   = s6.hm - esc_pkg::asr32(s6.hq * h1, 4);
    s7           <= s7_next;
  end

  always_ff @(posedge clk) begin
    bk_t s8_next;
    s8_next    = s7;
    s8_next.v1 = esc_pkg::asr64(esc_pkg::mul_sum(s7.pa), 33);
    s8_next.pb = esc_pkg::mul_pp(s7.numa, esc_pkg::P_SCALE);
    if (s7.hr[31]) begin
      s8_next.hum = '0;
    end else if (s7.hr > esc_pkg::H_MAX) begin
      s8_next.hum = esc_pkg::H_MAX[28:12];
    end else begin
      s8_next.hum = s7.hr[28:12];
    end
    s8 <= s8_next;
  end

  always_ff @(posedge clk) begin
    bk_t s9_next;
    s9_next     = s8;
    s9_next.num = esc_pkg::mul_sum(s8.pb);
    s9          <= s9_next;
  end

  // Divide
  esc_pkg::side_t dside, oside;
  logic           dvld;
  logic [63:0]    quo;

  assign dside.temp  = s9.temp;
  assign dside.hum   = s9.hum;
  assign dside.valid = (s9.v1 != 64'd0);

  esc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld[9]),
    .num      (s9.num),
    .den      (s9.v1),
    .in_side  (dside),
    .out_vld  (dvld),
    .quo      (quo),
    .out_side (oside)
  );

  // Post-division correction
  pt_t        t1, t2, t3, t4, t5;
  logic [5:1] pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= '0;
      done <= 1'b0;
    end else begin
      pv   <= {pv[4:1], dvld};
      done <= pv[5];
    end
  end

  always_ff @(posedge clk) begin
    pt_t t1_next;
    t1_next      = '0;
    t1_next.p    = quo;
    t1_next.side = oside;
    t1_next.pa   = esc_pkg::mul_pp(esc_pkg::asr64(quo, 13), esc_pkg::asr64(quo, 13));
    t1_next.pb   = esc_pkg::mul_pp(p8, quo);
    t1           <= t1_next;
  end

  always_ff @(posedge clk) begin
    pt_t t2_next;
    t2_next     = t1;
    t2_next.qq  = esc_pkg::mul_sum(t1.pa);
    t2_next.p8p = esc_pkg::mul_sum(t1.pb);
    t2          <= t2_next;
  end

  always_ff @(posedge clk) begin
    pt_t t3_next;
    t3_next    = t2;
    t3_next.pa = esc_pkg::mul_pp(t2.qq, p9);
    t3         <= t3_next;
  end

  always_ff @(posedge clk) begin
    pt_t t4_next;
    t4_next     = t3;
    t4_next.v1b = esc_pkg::asr64(esc_pkg::mul_sum(t3.pa), 25);
    t4_next.v2b = esc_pkg::asr64(t3.p8p, 19);
    t4          <= t4_next;
  end

  always_ff @(posedge clk) begin
    pt_t t5_next;
    t5_next    = t4;
    t5_next.pr = esc_pkg::asr64(t4.p + t4.v1b + t4.v2b, 8) + (p7 << 4);
    t5         <= t5_next;
  end

  // Saturate and register the result
  always_ff @(posedge clk) begin
    result.temperature_centi <= t5.side.temp;
    result.humidity_q22_10   <= t5.side.hum;
    result.pressure_valid    <= t5.side.valid;
    if (!t5.side.valid || t5.pr[63]) begin
      result.pressure_q24_8 <= '0;
    end else if (t5.pr > esc_pkg::P_MAX) begin
      result.pressure_q24_8 <= '1;
    end else begin
      result.pressure_q24_8 <= t5.pr[31:0];
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
      done && !result.pressure_valid |-> result.pressure_q24_8 == 32'd0)
    else $error("invalid pressure not forced to zero");
  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
      done |-> result.humidity_q22_10 <= esc_pkg::H_MAX[28:12])
    else $error("humidity above clamp");
  a_div_follows: assert property (@(posedge clk) disable iff (rst) pv[1] |=> pv[2])
    else $error("post pipeline lost a beat");

endmodule
`default_nettype wire

// ===== sv/env_sensor_compensation.sv =====
// Top level of the environmental sensor compensation block.
//
//  channel   ports                          handshake
//  -------   -----------------------------  -----------------------------
//  sample    sample (in_t)                  start && !busy
//  result    result (out_t)                 done, one cycle, no back-pressure
//  config    cfg_we, cfg_index, cfg_data    cfg_we, index 0..4, others ignored
//
// One sample is taken per cycle while busy is low.
// The latency is set mostly by the 64-stage divider in the pressure path.
// Reset clears the coefficient registers, the queue and all valid bits.
// Nothing downstream stalls; busy rises only if the front-to-back queue fills.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire esc_pkg::in_t                       sample,
  output logic                                    done,
  output esc_pkg::out_t                           result,
  input  wire logic                               cfg_we,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  esc_pkg::cfg_t cfg;
  esc_pkg::q_t   fentry, qentry;
  logic          fpush, qvld, qfull;

  // Write coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::REG_TEMP:  cfg.t  <= cfg_data[47:0];
        esc_pkg::REG_PLOW:  cfg.pl <= cfg_data;
        esc_pkg::REG_PHIGH: cfg.ph <= cfg_data;
        esc_pkg::REG_MIXED: cfg.mx <= cfg_data[47:0];
        esc_pkg::REG_HUM:   cfg.hm <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign busy = qfull;

  esc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !busy),
    .sample (sample),
    .cfg    (cfg),
    .push   (fpush),
    .entry  (fentry)
  );

  esc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fpush),
    .wdata    (fentry),
    .pop      (qvld),
    .nonempty (qvld),
    .full     (qfull),
    .rdata    (qentry)
  );

  esc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .in_vld (qvld),
    .entry  (qentry),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the environmental sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int LATENCY = 88;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  esc_pkg::in_t sample = '0;
  logic done;
  esc_pkg::out_t result;
  logic cfg_we = 1'b0;
  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  env_sensor_compensation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Coefficient shadow copy
  logic [47:0] coef_t = '0;
  logic [63:0] coef_pl = '0;
  logic [63:0] coef_ph = '0;
  logic [47:0] coef_mx = '0;
  logic [39:0] coef_hm = '0;

  esc_pkg::out_t comp_expected[$];
  int fail_count = 0;
  longint cycle_count = 0;
  int send_idle_pct = 0;

  // Signed 64-bit division truncating toward zero, wrap on overflow
  function automatic logic [63:0] div_trunc(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] mn, md, q;
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    q = mn / md;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    return 64'($signed(x) >>> n);
  endfunction

  // Compute the compensated triple from raw readings and current coefficients
  function automatic esc_pkg::out_t compensate(input esc_pkg::in_t s);
    esc_pkg::out_t r;
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6, at, ah;
    logic [31:0] a, d, fine, temp, v, x, y, z, w, u, sq;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, f, v1, v2, p, press;
    logic valid;
    at = {12'b0, s.raw_temperature};
    ah = {16'b0, s.raw_humidity};
    t1 = {16'b0, coef_t[15:0]};
    t2 = {{16{coef_t[31]}}, coef_t[31:16]};
    t3 = {{16{coef_t[47]}}, coef_t[47:32]};
    p1 = {48'b0, coef_pl[15:0]};
    p2 = {{48{coef_pl[31]}}, coef_pl[31:16]};
    p3 = {{48{coef_pl[47]}}, coef_pl[47:32]};
    p4 = {{48{coef_pl[63]}}, coef_pl[63:48]};
    p5 = {{48{coef_ph[15]}}, coef_ph[15:0]};
    p6 = {{48{coef_ph[31]}}, coef_ph[31:16]};
    p7 = {{48{coef_ph[47]}}, coef_ph[47:32]};
    p8 = {{48{coef_ph[63]}}, coef_ph[63:48]};
    p9 = {{48{coef_mx[15]}}, coef_mx[15:0]};
    h1 = {24'b0, coef_mx[23:16]};
    h2 = {{16{coef_mx[39]}}, coef_mx[39:24]};
    h3 = {24'b0, coef_mx[47:40]};
    h4 = {{16{coef_hm[15]}}, coef_hm[15:0]};
    h5 = {{16{coef_hm[31]}}, coef_hm[31:16]};
    h6 = {{24{coef_hm[39]}}, coef_hm[39:32]};

    // temperature
    a = sra32((sra32(at, 3) - (t1 << 1)) * t2, 11);
    d = sra32(at, 4) - t1;
    fine = a + sra32(sra32(d * d, 12) * t3, 14);
    temp = sra32(fine * 32'd5 + 32'd128, 8);

    // pressure
    f = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = f * f * p6;
    v2 = v2 + ((f * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(f * f * p3, 8) + ((f * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      press = 0;
      valid = 1'b0;
    end else begin
      p = 64'd1048576 - {44'b0, s.raw_pressure};
      p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
      v2 = sra64(p8 * p, 19);
      p = sra64(p + v1 + v2, 8) + (p7 << 4);
      if (p[63]) press = 0;
      else if (p > 64'hFFFF_FFFF) press = 64'hFFFF_FFFF;
      else press = p;
      valid = 1'b1;
    end

    // humidity
    v = fine - 32'd76800;
    x = sra32((ah << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    y = sra32(v * h6, 10);
    z = sra32(v * h3, 11) + 32'd32768;
    w = sra32(y * z, 10) + 32'd2097152;
    u = sra32(w * h2 + 32'd8192, 14);
    v = x * u;
    sq = sra32(v, 15);
    v = v - sra32(sra32(sq * sq, 7) * h1, 4);
    if (v[31]) v = 0;
    else if (v > 32'd419430400) v = 32'd419430400;

    r.temperature_centi = temp;
    r.pressure_q24_8 = press[31:0];
    r.pressure_valid = valid;
    r.humidity_q22_10 = v[28:12];
    return r;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    esc_pkg::out_t exp_r;
    if (!rst && done) begin
      if (comp_expected.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result %h", $time, result);
      end else begin
        exp_r = comp_expected.pop_front();
        if (result.temperature_centi !== exp_r.temperature_centi) begin
          fail_count++;
          $display("%0t temperature exp %h got %h", $time,
                   exp_r.temperature_centi, result.temperature_centi);
        end
        if (result.pressure_q24_8 !== exp_r.pressure_q24_8) begin
          fail_count++;
          $display("%0t pressure exp %h got %h", $time,
                   exp_r.pressure_q24_8, result.pressure_q24_8);
        end
        if (result.pressure_valid !== exp_r.pressure_valid) begin
          fail_count++;
          $display("%0t pressure_valid exp %b got %b", $time,
                   exp_r.pressure_valid, result.pressure_valid);
        end
        if (result.humidity_q22_10 !== exp_r.humidity_q22_10) begin
          fail_count++;
          $display("%0t humidity exp %h got %h", $time,
                   exp_r.humidity_q22_10, result.humidity_q22_10);
        end
      end
    end
  end

  // Send one sample beat; start stays high across back-to-back beats
  task automatic send_sample(input esc_pkg::in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    comp_expected.push_back(compensate(s));
  endtask

  // Release start and wait for every expected result, then the pipeline tail
  task automatic drain;
    int n;
    start <= 1'b0;
    @(posedge clk);
    while (comp_expected.size() != 0) @(posedge clk);
    for (n = 0; n < LATENCY + 8; n++) @(posedge clk);
  endtask

  task automatic write_reg(input logic [esc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      esc_pkg::REG_TEMP:  coef_t = data[47:0];
      esc_pkg::REG_PLOW:  coef_pl = data;
      esc_pkg::REG_PHIGH: coef_ph = data;
      esc_pkg::REG_MIXED: coef_mx = data[47:0];
      esc_pkg::REG_HUM:   coef_hm = data[39:0];
      default: ;
    endcase
  endtask

  function automatic esc_pkg::in_t rand_sample();
    esc_pkg::in_t s;
    s.raw_temperature = 20'($urandom);
    s.raw_pressure = 20'($urandom);
    s.raw_humidity = 16'($urandom);
    return s;
  endfunction

  // Typical factory coefficients, with optional random jitter
  task automatic load_typical(input bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    write_reg(esc_pkg::REG_TEMP, 64'({16'd50, 16'd26435 + j, 16'd27504}));
    write_reg(esc_pkg::REG_PLOW, {16'd2855 + j, 16'd8192, -16'sd10685, 16'd36477});
    write_reg(esc_pkg::REG_PHIGH, {-16'sd12000, 16'd15500, -16'sd7, 16'd140 + j});
    write_reg(esc_pkg::REG_MIXED, 64'({8'd0, 16'd360 + j, 8'd75, 16'd6000}));
    write_reg(esc_pkg::REG_HUM, 64'({8'd30, 16'd50, 16'd339 + j}));
  endtask

  task automatic load_random;
    write_reg(esc_pkg::REG_TEMP, {$urandom, $urandom});
    write_reg(esc_pkg::REG_PLOW, {$urandom, $urandom});
    write_reg(esc_pkg::REG_PHIGH, {$urandom, $urandom});
    write_reg(esc_pkg::REG_MIXED, {$urandom, $urandom});
    write_reg(esc_pkg::REG_HUM, {$urandom, $urandom});
    // out-of-range index must be ignored
    cfg_we <= 1'b1;
    cfg_index <= 3'(5 + $urandom_range(2));
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset coefficients: zero divisor, pressure invalid
  task automatic test_reset_coeffs;
    send_sample('0);
    send_sample('1);
    send_sample(rand_sample());
    drain();
  endtask

  // Field extremes under typical and extreme coefficients
  task automatic test_extremes;
    int k;
    esc_pkg::in_t s;
    load_typical(1'b0);
    for (k = 0; k < 8; k++) begin
      s.raw_temperature = k[0] ? 20'hFFFFF : 20'h0;
      s.raw_pressure = k[1] ? 20'hFFFFF : 20'h0;
      s.raw_humidity = k[2] ? 16'hFFFF : 16'h0;
      send_sample(s);
    end
    send_sample('{20'd519888, 20'd415148, 16'd30000});
    drain();
    write_reg(esc_pkg::REG_TEMP, 64'hFFFF_FFFF_FFFF);
    write_reg(esc_pkg::REG_PLOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(esc_pkg::REG_PHIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(esc_pkg::REG_MIXED, 64'hFFFF_FFFF_FFFF);
    write_reg(esc_pkg::REG_HUM, 64'hFF_FFFF_FFFF);
    send_sample('0);
    send_sample('1);
    drain();
    write_reg(esc_pkg::REG_TEMP, 64'h8000_8000_FFFF);
    write_reg(esc_pkg::REG_PLOW, 64'h8000_8000_8000_FFFF);
    write_reg(esc_pkg::REG_PHIGH, 64'h8000_8000_8000_8000);
    write_reg(esc_pkg::REG_MIXED, 64'hFF80_00FF_8000);
    write_reg(esc_pkg::REG_HUM, 64'h80_8000_8000);
    send_sample('0);
    send_sample('1);
    send_sample(rand_sample());
    drain();
  endtask

  // Random samples under several coefficient sets and idle patterns
  task automatic test_random_samples;
    int ph, k;
    int idle_sel[4] = '{0, 68, 0, 13};
    for (ph = 0; ph < 8; ph++) begin
      send_idle_pct = idle_sel[ph % 4];
      if (ph % 3 == 2) load_random();
      else load_typical(1'b1);
      for (k = 0; k < 170; k++) send_sample(rand_sample());
      drain();
    end
    send_idle_pct = 0;
  endtask

  initial begin
    int n;
    for (n = 0; n < 12; n++) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_coeffs();
    test_extremes();
    test_random_samples();
    if (fail_count == 0 && comp_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/esc_pkg.sv
sv/esc_front.sv
sv/esc_fifo.sv
sv/esc_div.sv
sv/esc_back.sv
sv/env_sensor_compensation.sv
verif/tb_top.sv
